/* src/hvbs_pkg.sv */
// Shared types and constants for the HSV value scaling pipeline.
package hvbs_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned GainW  = 12;
  localparam int unsigned NCells = ChanW;

  localparam logic [GainW-1:0] GAIN_ONE = 12'd256;
  localparam logic [ChanW-1:0] CHAN_MAX = 8'd255;

  // One channel inside the divider row: the partial remainder and a shift
  // register that gives up dividend bits at the top and takes quotient bits
  // in at the bottom.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] bits;
  } chan_t;

  // Everything one divider cell passes to its neighbour.
  typedef struct packed {
    logic [ChanW-1:0] divisor;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
  } cell_data_t;

endpackage

/* src/hsv_value_brightness_scale_top.sv */
// Top level of the HSV value scaling block: gain register, front end and divider row.
//
// Each pixel item is scaled so that its largest channel moves to
// min(floor(max * gain / 256), 255) while hue and saturation are kept: every
// channel becomes floor(c * target / max), and a black pixel stays black.
// The block takes one pixel every clock unless the output stalls. Each pixel passes
// through three front-end stages (maximum, value times gain, channel products) and
// then a row of eight identical division cells, each
// resolving one quotient bit for all three channels. The whole pipeline moves
// together; it advances whenever the output register is empty or its item is
// being taken, so s_tready follows m_tready combinationally and a stall on the
// output holds every stage. The gain is written through gain_we/gain_wdata and
// should be changed only while no pixel is in flight; it resets to 256 (unity).
module hsv_value_brightness_scale_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration: gain, unsigned Q4.8.
  input  logic        gain_we,
  input  logic [11:0] gain_wdata,
  // Input pixels.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
  // Result pixels.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // out_red [7:0], out_green [15:8], out_blue [23:16]
);

  logic [hvbs_pkg::GainW-1:0] gain;
  logic                       en;

  // Valid bits and data between neighbouring cells; index 0 is the front end.
  logic                       valid_chain [hvbs_pkg::NCells+1];
  hvbs_pkg::cell_data_t       data_chain  [hvbs_pkg::NCells+1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= hvbs_pkg::GAIN_ONE;
    end else if (gain_we) begin
      gain <= gain_wdata;
    end
  end

  hvbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_red    (s_tdata[7:0]),
    .in_green  (s_tdata[15:8]),
    .in_blue   (s_tdata[23:16]),
    .gain      (gain),
    .out_valid (valid_chain[0]),
    .out_data  (data_chain[0])
  );

  // The divider row: each cell shifts one more quotient bit into every channel.
  for (genvar i = 0; i < hvbs_pkg::NCells; i++) begin : g_cell
    hvbs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_chain[i]),
      .in_data   (data_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_data  (data_chain[i+1])
    );
  end

  // The last cell's registers act as the output register.
  assign m_tvalid = valid_chain[hvbs_pkg::NCells];
  assign m_tdata  = {data_chain[hvbs_pkg::NCells].blue.bits,
                     data_chain[hvbs_pkg::NCells].green.bits,
                     data_chain[hvbs_pkg::NCells].red.bits};

endmodule

/* src/hvbs_front.sv */
// Front end: maximum channel, target value and the three channel products.
module hvbs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [hvbs_pkg::ChanW-1:0]     in_red,
  input  logic [hvbs_pkg::ChanW-1:0]     in_green,
  input  logic [hvbs_pkg::ChanW-1:0]     in_blue,
  input  logic [hvbs_pkg::GainW-1:0]     gain,
  output logic                           out_valid,
  output hvbs_pkg::cell_data_t           out_data
);

  localparam int unsigned ProdW = hvbs_pkg::ChanW + hvbs_pkg::GainW;

  // Stage one: the pixel as it came in.
  logic                       s1_valid;
  logic [hvbs_pkg::ChanW-1:0] s1_red, s1_green, s1_blue;

  // Stage two: the value times the gain, and the divisor.
  logic                       s2_valid;
  logic [hvbs_pkg::ChanW-1:0] s2_red, s2_green, s2_blue, s2_div;
  logic [ProdW-1:0]           s2_prod;

  logic [hvbs_pkg::ChanW-1:0] mx;
  logic [hvbs_pkg::ChanW-1:0] rg_max;
  logic [hvbs_pkg::ChanW-1:0] target;
  logic [2*hvbs_pkg::ChanW-1:0] p_red, p_green, p_blue;

  always_comb begin
    rg_max = (s1_red > s1_green) ? s1_red : s1_green;
    mx     = (rg_max > s1_blue) ? rg_max : s1_blue;
  end

  // Target saturates at full scale; the product keeps eight fraction bits.
  always_comb begin
    if (s2_prod[ProdW-1:2*hvbs_pkg::ChanW] != '0) begin
      target = hvbs_pkg::CHAN_MAX;
    end else begin
      target = s2_prod[2*hvbs_pkg::ChanW-1:hvbs_pkg::ChanW];
    end
    p_red   = s2_red   * target;
    p_green = s2_green * target;
    p_blue  = s2_blue  * target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_red   <= in_red;
      s1_green <= in_green;
      s1_blue  <= in_blue;

      s2_red   <= s1_red;
      s2_green <= s1_green;
      s2_blue  <= s1_blue;
      s2_prod  <= mx * gain;
      // A black pixel has all products at zero, so a divisor of one gives zero.
      s2_div   <= (mx == '0) ? hvbs_pkg::ChanW'(1) : mx;

      out_data.divisor    <= s2_div;
      out_data.red.rem    <= p_red[2*hvbs_pkg::ChanW-1:hvbs_pkg::ChanW];
      out_data.red.bits   <= p_red[hvbs_pkg::ChanW-1:0];
      out_data.green.rem  <= p_green[2*hvbs_pkg::ChanW-1:hvbs_pkg::ChanW];
      out_data.green.bits <= p_green[hvbs_pkg::ChanW-1:0];
      out_data.blue.rem   <= p_blue[2*hvbs_pkg::ChanW-1:hvbs_pkg::ChanW];
      out_data.blue.bits  <= p_blue[hvbs_pkg::ChanW-1:0];
    end
  end

endmodule

/* src/hvbs_cell.sv */
// One restoring division step for all three channels, registered.
module hvbs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  hvbs_pkg::cell_data_t in_data,
  output logic                 out_valid,
  output hvbs_pkg::cell_data_t out_data
);

  function automatic hvbs_pkg::chan_t div_step(input hvbs_pkg::chan_t c,
                                               input logic [hvbs_pkg::ChanW-1:0] d);
    logic [hvbs_pkg::ChanW:0] trial;
    logic [hvbs_pkg::ChanW:0] diff;
    hvbs_pkg::chan_t          r;
    trial = {c.rem, c.bits[hvbs_pkg::ChanW-1]};
    diff  = trial - {1'b0, d};
    // The remainder stays below the divisor, so it always fits the channel width.
    if (trial >= {1'b0, d}) begin
      r.rem  = diff[hvbs_pkg::ChanW-1:0];
      r.bits = {c.bits[hvbs_pkg::ChanW-2:0], 1'b1};
    end else begin
      r.rem  = trial[hvbs_pkg::ChanW-1:0];
      r.bits = {c.bits[hvbs_pkg::ChanW-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.divisor <= in_data.divisor;
      out_data.red     <= div_step(in_data.red,   in_data.divisor);
      out_data.green   <= div_step(in_data.green, in_data.divisor);
      out_data.blue    <= div_step(in_data.blue,  in_data.divisor);
    end
  end

endmodule

/* src/hvbs_checker.sv */
// Port-level checks for the HSV value scaling block, bound to its top level.
module hvbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A result that is not taken stays offered.
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A result that is not taken keeps its value.
  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // With the output register empty the pipeline is free to move.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // The pipeline is emptied by reset.
  a_empty_after_reset : assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind hsv_value_brightness_scale_top hvbs_checker u_hvbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
